/* rtl/core/vmm_pkg.sv */
// vmm_pkg: shared types and constants for the vector-matrix multiply block.
// Depends on nothing; imported by vector_matrix_multiply.
`timescale 1ns / 1ps
`default_nettype none

package vmm_pkg;

    // Fixed field widths
    localparam int VAL_W  = 16;   // Q8.8 element
    localparam int PROD_W = 32;   // Q16.16 product
    localparam int SUM_W  = 38;   // Q22.16 column sum
    localparam int IDX_W  = 6;    // vector index and column index ports
    localparam int CFG_W  = 7;    // register data width

    // Operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_MATRIX = 1'b1;

    // Register indexes
    localparam logic REG_VECTOR_LENGTH = 1'b0;
    localparam logic REG_COLUMN_COUNT  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DRAIN,
        S_FLUSH
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/vector_matrix_multiply.sv */
// vector_matrix_multiply: row vector times matrix, signed Q8.8 in, Q22.16 sums out.
// Depends on vmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Load vector elements first (operation 0), then stream the matrix row by row
// (operation 1). A matrix element passes in order through the single shared
// multiply-accumulate path: vector store and accumulator read, 16x16 multiply, add
// and write back, with o_busy high until the write back. The element that closes the
// matrix then keeps the block busy while the sums are read out of the accumulator
// memory, one column per cycle. Each sum is shown on o_column_index, o_sum and
// o_last for exactly one cycle with o_strobe high; the receiver cannot stall, so it
// must take every strobed result. Accumulators clear through per-column valid bits
// at the end of readout, so no clearing pass follows reset.
module vector_matrix_multiply #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // command channel
    input  wire logic                           i_start,
    output      logic                           o_busy,
    input  wire logic                           i_operation,
    input  wire logic [vmm_pkg::IDX_W-1:0]      i_vector_index,
    input  wire logic signed [vmm_pkg::VAL_W-1:0] i_value,
    // result channel
    output      logic                           o_strobe,
    output      logic [vmm_pkg::IDX_W-1:0]      o_column_index,
    output      logic signed [vmm_pkg::SUM_W-1:0] o_sum,
    output      logic                           o_last,
    // configuration channel
    input  wire logic                           i_cfg_valid,
    output      logic                           o_cfg_ready,
    input  wire logic                           i_cfg_index,
    input  wire logic [vmm_pkg::CFG_W-1:0]      i_cfg_data
);
    import vmm_pkg::*;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CMP_W  = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

    // Storage
    logic signed [VAL_W-1:0] vec_mem [MAX_ROWS];
    logic signed [SUM_W-1:0] sum_mem [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0]  r_sum_vld;

    // Control and datapath registers
    t_state                  r_state, n_state;
    logic [ROW_W-1:0]        r_row, n_row;
    logic [COL_W-1:0]        r_col, n_col;
    logic [COL_W-1:0]        r_drain, n_drain;
    logic [CFG_W-1:0]        r_vec_len, r_col_cnt;
    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] r_vec_q;
    logic signed [SUM_W-1:0] r_sum_q;
    logic                    r_rd_vld;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_strobe;
    logic [COL_W-1:0]        r_out_col;
    logic                    r_out_last;

    logic                    accept;
    logic                    cfg_xfer;
    logic [CMP_W-1:0]        rows_eff;
    logic [CFG_W-1:0]        cols_eff;
    logic [CMP_W-1:0]        row_inc;
    logic [CFG_W-1:0]        col_inc;
    logic [CFG_W-1:0]        drain_inc;
    logic [CMP_W-1:0]        ld_idx;
    logic                    ld_ok;
    logic [COL_W-1:0]        sum_rd_addr;
    logic signed [SUM_W-1:0] acc_in;
    logic signed [SUM_W-1:0] acc_out;
    logic                    do_issue;
    logic                    do_write;
    logic                    do_clear;

    assign accept   = i_start && !o_busy;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;

    // Clamp register values to the legal bounds
    always_comb begin
        if (r_vec_len == '0) begin
            rows_eff = CMP_W'(1);
        end else if (CMP_W'(r_vec_len) > CMP_W'(MAX_ROWS)) begin
            rows_eff = CMP_W'(MAX_ROWS);
        end else begin
            rows_eff = CMP_W'(r_vec_len);
        end
        if (r_col_cnt == '0) begin
            cols_eff = CFG_W'(1);
        end else if (r_col_cnt > CFG_W'(MAX_COLUMNS)) begin
            cols_eff = CFG_W'(MAX_COLUMNS);
        end else begin
            cols_eff = r_col_cnt;
        end
    end

    assign row_inc   = CMP_W'(r_row) + CMP_W'(1);
    assign col_inc   = CFG_W'(r_col) + CFG_W'(1);
    assign drain_inc = CFG_W'(r_drain) + CFG_W'(1);
    assign ld_idx    = CMP_W'(i_vector_index);
    assign ld_ok     = ld_idx < CMP_W'(MAX_ROWS);

    // Shared accumulate: invalid entries read as zero
    assign acc_in  = r_rd_vld ? r_sum_q : '0;
    assign acc_out = acc_in + SUM_W'(r_prod);

    // Sequencer next state and counters
    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_drain  = r_drain;
        do_issue = 1'b0;
        do_write = 1'b0;
        do_clear = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_operation == OP_MATRIX) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                do_write = 1'b1;
                if (col_inc < cols_eff) begin
                    n_col   = COL_W'(col_inc);
                    n_state = S_IDLE;
                end else begin
                    n_col = '0;
                    if (row_inc < rows_eff) begin
                        n_row   = ROW_W'(row_inc);
                        n_state = S_IDLE;
                    end else begin
                        n_row   = '0;
                        n_drain = '0;
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                do_issue = 1'b1;
                n_drain  = COL_W'(drain_inc);
                if (drain_inc == cols_eff) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                do_clear = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign sum_rd_addr = (r_state == S_DRAIN) ? r_drain : r_col;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_drain   <= '0;
            r_strobe  <= 1'b0;
            r_sum_vld <= '0;
            r_vec_len <= CFG_W'(1);
            r_col_cnt <= CFG_W'(1);
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_drain  <= n_drain;
            r_strobe <= do_issue;
            if (do_clear) begin
                r_sum_vld <= '0;
            end else if (do_write) begin
                r_sum_vld[r_col] <= 1'b1;
            end
            if (cfg_xfer) begin
                unique case (i_cfg_index)
                    REG_VECTOR_LENGTH: r_vec_len <= i_cfg_data;
                    REG_COLUMN_COUNT:  r_col_cnt <= i_cfg_data;
                    default:           r_vec_len <= r_vec_len;
                endcase
            end
        end
    end

    // Vector store: write on load, registered read at the current row
    always_ff @(posedge i_clk) begin
        if (accept && i_operation == OP_LOAD && ld_ok) begin
            vec_mem[ld_idx[ROW_W-1:0]] <= i_value;
        end
        r_vec_q <= vec_mem[r_row];
    end

    // Accumulator memory: write back on accumulate, registered read
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            sum_mem[r_col] <= acc_out;
        end
        r_sum_q  <= sum_mem[sum_rd_addr];
        r_rd_vld <= r_sum_vld[sum_rd_addr];
    end

    // Datapath registers: capture operand, multiply, tag readout
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value <= i_value;
        end
        r_prod     <= r_vec_q * r_value;
        r_out_col  <= r_drain;
        r_out_last <= (drain_inc == cols_eff);
    end

    // Outputs
    assign o_busy         = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_column_index = IDX_W'(r_out_col);
    assign o_sum          = r_rd_vld ? r_sum_q : '0;
    assign o_last         = r_out_last;

    // A result transfer always follows a readout issue
    a_strobe_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == S_DRAIN))
        else $error("result strobe without readout issue");

    // The final column ends the readout
    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out_last) |=> (r_state == S_IDLE))
        else $error("readout continues after final column");

    // Accumulators are all clear once readout finishes
    a_clear_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> (r_sum_vld == '0))
        else $error("accumulators not cleared after readout");

    // Results only appear while busy
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy)
        else $error("result strobe while idle");

    // Multiply only follows an accepted matrix element
    a_mul_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> $past(r_state == S_IDLE))
        else $error("multiply step without accepted element");

endmodule

`default_nettype wire
